[rtl/lbpc_pkg.sv]
// Package for the LED blink pattern controller.
// Holds command codes, level codes, the per-channel command struct and the lamp drive function.
// No dependencies.
`default_nettype none

package lbpc_pkg;

  // Item kinds carried on the action field.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_FLASH = 2'd2
  } action_e;

  // Level codes for set commands and for the end level of a pattern.
  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_ON     = 2'd1,
    LVL_TOGGLE = 2'd2
  } level_e;

  // Addressed channel state reported for an unknown channel.
  localparam logic [1:0] ADDR_UNKNOWN = 2'd2;

  // Command broadcast from the top level to every channel.
  typedef struct packed {
    logic        tick;
    logic        set;
    logic        flash;
    logic [1:0]  level_cmd;
    logic [15:0] period;
    logic [15:0] on_len;
    logic [7:0]  count;
    logic [1:0]  end_level;
  } chan_cmd_t;

  // New lamp level for a level code; an unused code keeps the level.
  function automatic logic drive_lamp(logic [1:0] code, logic cur);
    logic res;
    res = cur;
    case (level_e'(code))
      LVL_OFF:    res = 1'b0;
      LVL_ON:     res = 1'b1;
      LVL_TOGGLE: res = ~cur;
      default:    res = cur;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/lbpc_channel.sv]
// One LED channel: pattern registers, elapsed counter and lamp level.
// Depends on lbpc_pkg for the command struct and the lamp drive function.
`default_nettype none

module lbpc_channel
  import lbpc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_en_i,
  input  wire chan_cmd_t cmd_i,
  input  wire logic      sel_i,
  output logic           lamp_d_o,
  output logic           lamp_o,
  output logic           active_d_o,
  output logic           active_o
);

  logic [15:0] period_q, period_d;
  logic [15:0] on_len_q, on_len_d;
  logic [8:0]  remaining_q, remaining_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        lamp_q, lamp_d;
  logic [1:0]  final_q, final_d;
  logic [15:0] elapsed_inc;
  logic [8:0]  remaining_dec;

  assign elapsed_inc   = elapsed_q + 16'd1;
  assign remaining_dec = remaining_q - 9'd1;

  // Next state for a tick, a set command or a flash command.
  always_comb begin
    period_d    = period_q;
    on_len_d    = on_len_q;
    remaining_d = remaining_q;
    elapsed_d   = elapsed_q;
    lamp_d      = lamp_q;
    final_d     = final_q;
    if (cmd_en_i && cmd_i.tick && (period_q != 16'd0)) begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc == on_len_q) begin
        lamp_d = 1'b0;
      end else if (elapsed_inc >= period_q) begin
        if (remaining_q == 9'd0) begin
          elapsed_d = 16'd0;
          lamp_d    = 1'b1;
        end else begin
          remaining_d = remaining_dec;
          if (remaining_dec == 9'd1) begin
            period_d = 16'd0;
            on_len_d = 16'd0;
            lamp_d   = drive_lamp(final_q, lamp_q);
          end else begin
            elapsed_d = 16'd0;
            lamp_d    = 1'b1;
          end
        end
      end
    end else if (cmd_en_i && cmd_i.set && sel_i) begin
      period_d = 16'd0;
      lamp_d   = drive_lamp(cmd_i.level_cmd, lamp_q);
    end else if (cmd_en_i && cmd_i.flash && sel_i) begin
      elapsed_d   = 16'd0;
      period_d    = 16'd0;
      on_len_d    = 16'd0;
      remaining_d = 9'd0;
      if (cmd_i.on_len == 16'd0) begin
        lamp_d = 1'b0;
      end else if (cmd_i.on_len >= cmd_i.period) begin
        lamp_d = 1'b1;
      end else begin
        remaining_d = (cmd_i.count != 8'd0) ? ({1'b0, cmd_i.count} + 9'd1) : 9'd0;
        on_len_d    = cmd_i.on_len;
        final_d     = cmd_i.end_level;
        period_d    = cmd_i.period;
        lamp_d      = 1'b1;
      end
    end
  end

  // Channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= '0;
      on_len_q    <= '0;
      remaining_q <= '0;
      elapsed_q   <= '0;
      lamp_q      <= 1'b0;
      final_q     <= '0;
    end else begin
      period_q    <= period_d;
      on_len_q    <= on_len_d;
      remaining_q <= remaining_d;
      elapsed_q   <= elapsed_d;
      lamp_q      <= lamp_d;
      final_q     <= final_d;
    end
  end

  assign lamp_d_o   = lamp_d;
  assign lamp_o     = lamp_q;
  assign active_d_o = (period_d != 16'd0);
  assign active_o   = (period_q != 16'd0);

endmodule

`default_nettype wire

[rtl/lbpc_out_fifo.sv]
// Two-word result buffer between the update logic and the output channel.
// Lets the block take a new item while a finished result waits. No package use.
`default_nettype none

module lbpc_out_fifo #(
  parameter int WIDTH = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Data slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/led_blink_pattern_controller.sv]
// LED blink pattern controller, top level.
// Uses lbpc_pkg, lbpc_channel (one per lamp) and lbpc_out_fifo (result buffer).
//
// Usage: input words arrive on in_valid_i/in_ready_o and carry a tick (one
// 10 ms period), a set-level command or a start-flash command. Each accepted
// word updates the per-channel registers in the same clock edge and produces
// exactly one result word on out_valid_o/out_ready_i: all lamp levels, the
// flashing flags and the addressed channel's lamp (or "unknown" for a channel
// at or above CHANNELS).
// The result word is registered in the output buffer before it is offered.
// Throughput: one word per cycle while the buffer has room; the state update
// is a single compare, increment and select path per channel.
// A two-word result buffer sits on the output, so an input word is still
// taken while one result waits; in_ready_o drops only when both slots hold
// results that the receiver has not yet taken.
// Reset clears every channel: no pattern running, all lamps off, buffer empty.
`default_nettype none

module led_blink_pattern_controller
  import lbpc_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  channel_i,
  input  wire logic [1:0]  level_command_i,
  input  wire logic [15:0] period_ticks_i,
  input  wire logic [15:0] on_ticks_i,
  input  wire logic [7:0]  flash_count_i,
  input  wire logic [1:0]  end_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       lamps_o,
  output logic [1:0]       addressed_state_o,
  output logic [1:0]       flashing_o
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_PAD   = 1 << CH_IDX_W;
  localparam int RES_W    = 6;

  logic                in_fire;
  logic                fifo_full;
  logic                chan_valid;
  chan_cmd_t           cmd;
  logic [CHANNELS-1:0] lamp_next;
  logic [CHANNELS-1:0] lamp_cur;
  logic [CHANNELS-1:0] active_cur;
  logic [CHANNELS-1:0] active_next;
  logic [CH_PAD-1:0]   lamp_pad;
  logic [1:0]          res_lamps;
  logic [1:0]          res_flashing;
  logic [1:0]          res_addr;
  logic [RES_W-1:0]    res_word;
  logic [RES_W-1:0]    out_word;

  assign in_ready_o = !fifo_full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign chan_valid = ({24'd0, channel_i} < 32'(CHANNELS));

  // Decode the input word into the command seen by every channel.
  always_comb begin
    cmd           = '0;
    cmd.level_cmd = level_command_i;
    cmd.period    = period_ticks_i;
    cmd.on_len    = on_ticks_i;
    cmd.count     = flash_count_i;
    cmd.end_level = end_level_i;
    case (action_e'(action_i))
      ACT_TICK:  cmd.tick  = 1'b1;
      ACT_SET:   cmd.set   = 1'b1;
      ACT_FLASH: cmd.flash = 1'b1;
      default:   cmd.tick  = 1'b0;
    endcase
  end

  // One channel unit per lamp.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic sel;
    assign sel = chan_valid && (channel_i[CH_IDX_W-1:0] == CH_IDX_W'(c));
    lbpc_channel u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_en_i   (in_fire),
      .cmd_i      (cmd),
      .sel_i      (sel),
      .lamp_d_o   (lamp_next[c]),
      .lamp_o     (lamp_cur[c]),
      .active_d_o (active_next[c]),
      .active_o   (active_cur[c])
    );
  end

  // Result word, built from the post-update state of the first two channels.
  assign lamp_pad = CH_PAD'(lamp_next);
  for (genvar b = 0; b < 2; b++) begin : g_res
    if (b < CHANNELS) begin : g_has
      assign res_lamps[b]    = lamp_next[b];
      assign res_flashing[b] = active_next[b];
    end else begin : g_none
      assign res_lamps[b]    = 1'b0;
      assign res_flashing[b] = 1'b0;
    end
  end
  assign res_addr = chan_valid ? {1'b0, lamp_pad[channel_i[CH_IDX_W-1:0]]} : ADDR_UNKNOWN;
  assign res_word = {res_lamps, res_addr, res_flashing};

  lbpc_out_fifo #(
    .WIDTH (RES_W)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .data_i  (res_word),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .pop_i   (out_ready_i),
    .data_o  (out_word)
  );

  assign lamps_o           = out_word[5:4];
  assign addressed_state_o = out_word[3:2];
  assign flashing_o        = out_word[1:0];

  // A stall of the input side only happens with a result on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // The addressed state code is never the unused value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (addressed_state_o != 2'd3))
    else $error("addressed state carries an unused code");

  // A set command on channel 0 stops its pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (action_i == ACT_SET) && (channel_i == 8'd0)) |=> !active_cur[0])
    else $error("set command left channel 0 flashing");

  // Lamp registers follow the computed next level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (lamp_cur == $past(lamp_next)))
    else $error("lamp register differs from computed level");

endmodule

`default_nettype wire

[dv/lamp_result_checker.sv]
// Result checker for the LED blink pattern controller testbench.
// Watches both channels, predicts every result word from its own lamp model and compares.
// Depends on lbpc_pkg for the action and level codes.
`default_nettype none

module lamp_result_checker
  import lbpc_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  channel_i,
  input  wire logic [1:0]  level_command_i,
  input  wire logic [15:0] period_ticks_i,
  input  wire logic [15:0] on_ticks_i,
  input  wire logic [7:0]  flash_count_i,
  input  wire logic [1:0]  end_level_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [1:0]  lamps_i,
  input  wire logic [1:0]  addressed_state_i,
  input  wire logic [1:0]  flashing_i,
  output int               mismatches_o,
  output int               pending_o
);

  typedef struct packed {
    logic [1:0] lamps;
    logic [1:0] addressed;
    logic [1:0] flashing;
  } lamp_word_t;

  // Per-channel copy of the blink state.
  logic [15:0] period_q   [CHANNELS];
  logic [15:0] on_len_q   [CHANNELS];
  logic [8:0]  flashes_q  [CHANNELS];
  logic [15:0] elapsed_q  [CHANNELS];
  logic        lamp_q     [CHANNELS];
  logic [1:0]  end_lvl_q  [CHANNELS];

  lamp_word_t expected_lamps_q[$];
  int         fail_total;

  // New lamp level for a level code; the unused code leaves the lamp alone.
  function automatic logic next_level(logic [1:0] code, logic cur);
    logic lvl;
    lvl = cur;
    if (code == LVL_OFF) lvl = 1'b0;
    else if (code == LVL_ON) lvl = 1'b1;
    else if (code == LVL_TOGGLE) lvl = !cur;
    return lvl;
  endfunction

  // One 10 ms tick on every channel that runs a pattern.
  task automatic advance_tick();
    for (int c = 0; c < CHANNELS; c++) begin
      if (period_q[c] != 16'd0) begin
        elapsed_q[c] = elapsed_q[c] + 16'd1;
        if (elapsed_q[c] == on_len_q[c]) begin
          lamp_q[c] = 1'b0;
        end else if (elapsed_q[c] >= period_q[c]) begin
          if (flashes_q[c] == 9'd0) begin
            elapsed_q[c] = 16'd0;
            lamp_q[c]    = 1'b1;
          end else begin
            flashes_q[c] = flashes_q[c] - 9'd1;
            if (flashes_q[c] == 9'd1) begin
              // Last flash done: stop and apply the stored end level.
              period_q[c] = 16'd0;
              on_len_q[c] = 16'd0;
              lamp_q[c]   = next_level(end_lvl_q[c], lamp_q[c]);
            end else begin
              elapsed_q[c] = 16'd0;
              lamp_q[c]    = 1'b1;
            end
          end
        end
      end
    end
  endtask

  // Start a flash pattern, or settle to a steady level for degenerate lengths.
  task automatic load_pattern(input int ch);
    elapsed_q[ch] = 16'd0;
    period_q[ch]  = 16'd0;
    on_len_q[ch]  = 16'd0;
    flashes_q[ch] = 9'd0;
    if (on_ticks_i == 16'd0) begin
      lamp_q[ch] = 1'b0;
    end else if (on_ticks_i >= period_ticks_i) begin
      lamp_q[ch] = 1'b1;
    end else begin
      flashes_q[ch] = (flash_count_i != 8'd0) ? {1'b0, flash_count_i} + 9'd1 : 9'd0;
      on_len_q[ch]  = on_ticks_i;
      end_lvl_q[ch] = end_level_i;
      period_q[ch]  = period_ticks_i;
      lamp_q[ch]    = 1'b1;
    end
  endtask

  // Apply one accepted input word and queue the result it should give.
  task automatic predict_lamp_word();
    lamp_word_t res;
    logic       hit;
    int         ch;
    hit = (channel_i < CHANNELS);
    ch  = hit ? int'(channel_i) : 0;
    case (action_i)
      ACT_TICK: advance_tick();
      ACT_SET: begin
        if (hit) begin
          period_q[ch] = 16'd0;
          lamp_q[ch]   = next_level(level_command_i, lamp_q[ch]);
        end
      end
      ACT_FLASH: begin
        if (hit) load_pattern(ch);
      end
      default: ;
    endcase
    res = '0;
    for (int c = 0; c < CHANNELS && c < 2; c++) begin
      res.lamps[c]    = lamp_q[c];
      res.flashing[c] = (period_q[c] != 16'd0);
    end
    res.addressed = hit ? {1'b0, lamp_q[ch]} : ADDR_UNKNOWN;
    expected_lamps_q.push_back(res);
  endtask

  function automatic int field_differs(string name, logic [1:0] want, logic [1:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  // Compare one accepted result word with the oldest prediction.
  task automatic check_lamp_word();
    lamp_word_t want;
    if (expected_lamps_q.size() == 0) begin
      $display("%0t: result word with nothing expected, got lamps %0d state %0d flashing %0d",
               $time, lamps_i, addressed_state_i, flashing_i);
      fail_total++;
    end else begin
      want = expected_lamps_q.pop_front();
      fail_total += field_differs("lamps", want.lamps, lamps_i);
      fail_total += field_differs("addressed_state", want.addressed, addressed_state_i);
      fail_total += field_differs("flashing", want.flashing, flashing_i);
    end
  endtask

  // The result of this edge belongs to an earlier word, so check before predicting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        period_q[c]  = 16'd0;
        on_len_q[c]  = 16'd0;
        flashes_q[c] = 9'd0;
        elapsed_q[c] = 16'd0;
        lamp_q[c]    = 1'b0;
        end_lvl_q[c] = 2'd0;
      end
      expected_lamps_q.delete();
      fail_total = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_lamp_word();
      if (in_valid_i && in_ready_i) predict_lamp_word();
      mismatches_o <= fail_total;
      pending_o    <= expected_lamps_q.size();
    end
  end

endmodule

`default_nettype wire

[dv/led_blink_pattern_controller_test.sv]
// Testbench top for the LED blink pattern controller.
// Drives directed and random words with random gaps and stalls; lamp_result_checker judges.
// Depends on lbpc_pkg, led_blink_pattern_controller and lamp_result_checker.
`default_nettype none

module led_blink_pattern_controller_test;
  import lbpc_pkg::*;

  localparam int CHANNELS = 2;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASE_WORDS = 352;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] LVL_KEEP = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [7:0]  channel_i;
  logic [1:0]  level_command_i;
  logic [15:0] period_ticks_i;
  logic [15:0] on_ticks_i;
  logic [7:0]  flash_count_i;
  logic [1:0]  end_level_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  lamps_o;
  logic [1:0]  addressed_state_o;
  logic [1:0]  flashing_o;

  int mismatches;
  int pending_words;
  int idle_pct;
  int stall_pct;
  int stuck_cycles;

  led_blink_pattern_controller #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .action_i(action_i),
    .channel_i(channel_i),
    .level_command_i(level_command_i),
    .period_ticks_i(period_ticks_i),
    .on_ticks_i(on_ticks_i),
    .flash_count_i(flash_count_i),
    .end_level_i(end_level_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .lamps_o(lamps_o),
    .addressed_state_o(addressed_state_o),
    .flashing_o(flashing_o)
  );

  lamp_result_checker #(
    .CHANNELS(CHANNELS)
  ) checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_i(in_ready_o),
    .action_i(action_i),
    .channel_i(channel_i),
    .level_command_i(level_command_i),
    .period_ticks_i(period_ticks_i),
    .on_ticks_i(on_ticks_i),
    .flash_count_i(flash_count_i),
    .end_level_i(end_level_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .lamps_i(lamps_o),
    .addressed_state_i(addressed_state_o),
    .flashing_i(flashing_o),
    .mismatches_o(mismatches),
    .pending_o(pending_words)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Receiver: ready drops at random with the current stall rate.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one word, after an optional random gap, and hold it until taken.
  task automatic send_word(input logic [1:0] act, input logic [7:0] ch,
                           input logic [1:0] lvl, input logic [15:0] per,
                           input logic [15:0] on_len, input logic [7:0] cnt,
                           input logic [1:0] endl);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    channel_i       <= ch;
    level_command_i <= lvl;
    period_ticks_i  <= per;
    on_ticks_i      <= on_len;
    flash_count_i   <= cnt;
    end_level_i     <= endl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Word of the given action with every other field random.
  task automatic send_scrambled(input logic [1:0] act, input logic [7:0] ch);
    send_word(act, ch, 2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
              2'($urandom_range(3)));
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  // Mostly a pattern start followed by a run of ticks, plus stray words.
  task automatic run_random(input int words);
    int          sent;
    int          burst;
    int          pick;
    logic [7:0]  ch;
    logic [15:0] per;
    logic [15:0] on_len;
    logic [7:0]  cnt;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        ch  = 8'($urandom_range(CHANNELS - 1));
        per = 16'($urandom_range(9, 2));
        if ($urandom_range(9) == 0) on_len = 16'(per + $urandom_range(3));
        else if ($urandom_range(19) == 0) on_len = 16'd0;
        else on_len = 16'($urandom_range(per - 1, 1));
        pick = $urandom_range(99);
        if (pick < 25) cnt = 8'd0;
        else if (pick < 85) cnt = 8'($urandom_range(4, 1));
        else cnt = 8'($urandom_range(255));
        burst = $urandom_range(30, 1);
        // Keep the phase within its word budget.
        if (burst > words - sent - 1) burst = words - sent - 1;
        send_word(ACT_FLASH, ch, 2'($urandom_range(3)), per, on_len, cnt,
                  2'($urandom_range(3)));
        repeat (burst) begin
          if ($urandom_range(99) < 10) begin
            send_scrambled(2'($urandom_range(2, 1)), 8'($urandom_range(CHANNELS - 1)));
          end else begin
            send_scrambled(ACT_TICK, 8'($urandom_range(255)));
          end
        end
        sent += burst + 1;
      end else begin
        if ($urandom_range(1) == 0) ch = 8'($urandom_range(255));
        else ch = 8'($urandom_range(CHANNELS - 1));
        send_scrambled(2'($urandom_range(3)), ch);
        sent++;
      end
    end
  endtask

  initial begin
    idle_pct        = 0;
    stall_pct       = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_TICK;
    channel_i       <= 8'd0;
    level_command_i <= LVL_OFF;
    period_ticks_i  <= 16'd0;
    on_ticks_i      <= 16'd0;
    flash_count_i   <= 8'd0;
    end_level_i     <= LVL_OFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: every action and level code, the channel limits,
    // degenerate on lengths, a finite pattern to its end and a forever one.
    send_word(ACT_TICK, 8'd0, LVL_OFF, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd0, LVL_ON, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd1, LVL_TOGGLE, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd0, LVL_TOGGLE, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd1, LVL_KEEP, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd0, LVL_OFF, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd2, LVL_ON, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SET, 8'd255, LVL_ON, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_SPARE, 8'd0, LVL_KEEP, 16'hFFFF, 16'hFFFF, 8'd255, LVL_KEEP);
    send_word(ACT_FLASH, 8'd0, LVL_OFF, 16'd5, 16'd0, 8'd3, LVL_ON);
    send_word(ACT_FLASH, 8'd1, LVL_OFF, 16'd4, 16'd4, 8'd3, LVL_ON);
    send_word(ACT_FLASH, 8'd0, LVL_OFF, 16'd0, 16'hFFFF, 8'd0, LVL_OFF);
    send_word(ACT_FLASH, 8'd255, LVL_OFF, 16'd3, 16'd1, 8'd1, LVL_ON);
    send_word(ACT_FLASH, 8'd1, LVL_KEEP, 16'hFFFF, 16'hFFFE, 8'd255, LVL_KEEP);
    send_word(ACT_FLASH, 8'd0, LVL_OFF, 16'd3, 16'd1, 8'd2, LVL_TOGGLE);
    repeat (7) send_word(ACT_TICK, 8'd0, LVL_OFF, 16'd0, 16'd0, 8'd0, LVL_OFF);
    send_word(ACT_FLASH, 8'd1, LVL_OFF, 16'd2, 16'd1, 8'd0, LVL_OFF);
    repeat (3) send_word(ACT_TICK, 8'd1, LVL_OFF, 16'd0, 16'd0, 8'd0, LVL_OFF);
    drain();

    // The largest flash count runs to its end: 255 flashes of two ticks each.
    send_word(ACT_FLASH, 8'd1, LVL_OFF, 16'd2, 16'd1, 8'd255, LVL_TOGGLE);
    repeat (514) send_word(ACT_TICK, 8'd0, LVL_OFF, 16'd0, 16'd0, 8'd0, LVL_OFF);
    drain();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    run_random(PHASE_WORDS);
    drain();
    idle_pct = 64;
    run_random(PHASE_WORDS);
    drain();
    idle_pct  = 0;
    stall_pct = 64;
    run_random(PHASE_WORDS);
    drain();
    idle_pct  = 6;
    stall_pct = 6;
    run_random(PHASE_WORDS);
    drain();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
